@@ rtl/rbct_pkg.sv @@
package rbct_pkg;

  localparam int unsigned OUTPUT_COUNT_DEF = 8;
  localparam int unsigned MaskW = 8;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned TimeW = 32;

  typedef enum logic [2:0] {
    REG_CTL_MASK    = 3'd0,
    REG_TEST_EN     = 3'd1,
    REG_ON_LEVEL    = 3'd2,
    REG_PRESS_LEVEL = 3'd3,
    REG_DEBOUNCE    = 3'd4,
    REG_STEP        = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_STEP,
    ST_PICK,
    ST_MOD,
    ST_SEARCH,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] now_ms;
    logic        button_level;
    logic [31:0] random_word;
    logic [3:0]  target_index;
    logic        target_on;
  } in_req_t;

  typedef struct packed {
    logic [7:0] relay_on_mask;
    logic       switched;
    logic [2:0] switched_index;
    logic       switched_on;
    logic       restarted;
    logic       pressed;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0]  controllable_mask;
    logic        click_test_enable;
    logic        relay_on_level;
    logic        button_pressed_level;
    logic [15:0] debounce_ms;
    logic [15:0] step_ms;
  } cfg_t;

endpackage

@@ rtl/rbct_regs.sv @@
module rbct_regs
  import rbct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_CTL_MASK:    cfg_d.controllable_mask    = pwdata[7:0];
        REG_TEST_EN:     cfg_d.click_test_enable    = pwdata[0];
        REG_ON_LEVEL:    cfg_d.relay_on_level       = pwdata[0];
        REG_PRESS_LEVEL: cfg_d.button_pressed_level = pwdata[0];
        REG_DEBOUNCE:    cfg_d.debounce_ms          = pwdata[15:0];
        REG_STEP:        cfg_d.step_ms              = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CTL_MASK:    prdata = DataW'(cfg_q.controllable_mask);
      REG_TEST_EN:     prdata = DataW'(cfg_q.click_test_enable);
      REG_ON_LEVEL:    prdata = DataW'(cfg_q.relay_on_level);
      REG_PRESS_LEVEL: prdata = DataW'(cfg_q.button_pressed_level);
      REG_DEBOUNCE:    prdata = DataW'(cfg_q.debounce_ms);
      REG_STEP:        prdata = DataW'(cfg_q.step_ms);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.controllable_mask    <= 8'd255;
      cfg_q.click_test_enable    <= 1'b0;
      cfg_q.relay_on_level       <= 1'b1;
      cfg_q.button_pressed_level <= 1'b0;
      cfg_q.debounce_ms          <= 16'd50;
      cfg_q.step_ms              <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/rbct_mod_unit.sv @@
module rbct_mod_unit
  import rbct_pkg::*;
#(
  parameter int unsigned CNT_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  localparam int unsigned StepW = $clog2(TimeW + 1);

  logic [TimeW-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0] div_q, div_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;
  logic [CNT_W:0]   trial;

  assign busy_o = (step_q != '0);
  assign done_o = done_q;
  assign rem_o  = rem_q;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[TimeW-1]};
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      step_d = StepW'(TimeW);
    end else if (busy_o) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = CNT_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      dvd_d  = {dvd_q[TimeW-2:0], 1'b0};
      step_d = step_q - StepW'(1);
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o) else $error("remainder start while busy");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_q < div_q)) else $error("remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy_o) else $error("remainder done not a pulse");

endmodule

@@ rtl/relay_bank_click_test_controller_core.sv @@
// A set request passes through the eval and finish states; a pass with no test
// step also goes through the step state, and one with a test step adds pick (and
// its retry), the remainder unit and the candidate search before finish.
// One request at a time: the next is taken the cycle after the result loads.
// Reset (async, active low): all pins low, button released, both times 0,
// switch-on phase, registers at their defaults.
module relay_bank_click_test_controller_core
  import rbct_pkg::*;
#(
  parameter int unsigned OUTPUT_COUNT = OUTPUT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_rsp_t         out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int unsigned CtlW = (OUTPUT_COUNT < MaskW) ? OUTPUT_COUNT : MaskW;
  localparam int unsigned IdxW = (CtlW > 1) ? $clog2(CtlW) : 1;
  localparam int unsigned CntW = $clog2(CtlW + 1);

  cfg_t       cfg;
  ctl_state_e state_q, state_d;
  in_req_t    req_q, req_d;

  logic [CtlW-1:0]  pins_q, pins_d;
  logic             was_down_q, was_down_d;
  logic [TimeW-1:0] lbt_q, lbt_d;
  logic [TimeW-1:0] lst_q, lst_d;
  logic             phase_q, phase_d;

  logic             sw_q, sw_d;
  logic [IdxW-1:0]  sw_idx_q, sw_idx_d;
  logic             sw_on_q, sw_on_d;
  logic             restarted_q, restarted_d;
  logic             pressed_q, pressed_d;
  logic             retry_q, retry_d;
  logic [CtlW-1:0]  cand_q, cand_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  nth_q, nth_d;

  out_rsp_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [CtlW-1:0]  ctl;
  logic [CtlW-1:0]  cand;
  logic [CntW-1:0]  cnt;
  logic             target;
  logic             has_ctl;
  logic [IdxW-1:0]  low_idx;
  logic [TimeW-1:0] elapsed;
  logic [15:0]      limit;
  logic             time_ok;
  logic             down;
  logic             mod_start, mod_busy, mod_done;
  logic [CntW-1:0]  mod_rem;
  logic [CtlW-1:0]  onm;

  rbct_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbct_mod_unit #(
    .CNT_W (CntW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (req_q.random_word),
    .divisor_i  (cnt),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign ctl         = cfg.controllable_mask[CtlW-1:0];
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign down        = (req_q.button_level == cfg.button_pressed_level);

  // one elapsed-time compare, shared by debounce and test step
  always_comb begin
    if (state_q == ST_STEP) begin
      elapsed = req_q.now_ms - lst_q;
      limit   = cfg.step_ms;
    end else begin
      elapsed = req_q.now_ms - lbt_q;
      limit   = cfg.debounce_ms;
    end
    time_ok = (elapsed >= {16'b0, limit});
  end

  // candidates: controllable pins not yet at the phase's target level
  always_comb begin
    target = phase_q ? cfg.relay_on_level : ~cfg.relay_on_level;
    cand   = ctl & (pins_q ^ {CtlW{target}});
    cnt    = '0;
    for (int i = 0; i < CtlW; i++) begin
      cnt = cnt + CntW'(cand[i]);
    end
  end

  always_comb begin
    has_ctl = 1'b0;
    low_idx = '0;
    for (int i = CtlW - 1; i >= 0; i--) begin
      if (ctl[i]) begin
        has_ctl = 1'b1;
        low_idx = IdxW'(i);
      end
    end
  end

  assign onm = ~(pins_q ^ {CtlW{cfg.relay_on_level}});

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pins_d      = pins_q;
    was_down_d  = was_down_q;
    lbt_d       = lbt_q;
    lst_d       = lst_q;
    phase_d     = phase_q;
    sw_d        = sw_q;
    sw_idx_d    = sw_idx_q;
    sw_on_d     = sw_on_q;
    restarted_d = restarted_q;
    pressed_d   = pressed_q;
    retry_d     = retry_q;
    cand_d      = cand_q;
    idx_d       = idx_q;
    nth_d       = nth_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mod_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d       = in_req_i;
          sw_d        = 1'b0;
          sw_idx_d    = '0;
          sw_on_d     = 1'b0;
          restarted_d = 1'b0;
          pressed_d   = 1'b0;
          retry_d     = 1'b0;
          state_d     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (req_q.mode) begin
          state_d = ST_FINISH;
          if (32'(req_q.target_index) < CtlW) begin
            if (ctl[req_q.target_index[IdxW-1:0]]) begin
              pins_d[req_q.target_index[IdxW-1:0]] =
                req_q.target_on ? cfg.relay_on_level : ~cfg.relay_on_level;
              sw_d     = 1'b1;
              sw_idx_d = req_q.target_index[IdxW-1:0];
              sw_on_d  = req_q.target_on;
            end
          end
        end else begin
          state_d = ST_STEP;
          if ((down != was_down_q) && time_ok) begin
            lbt_d      = req_q.now_ms;
            was_down_d = down;
            if (down) begin
              pressed_d = 1'b1;
              if (cfg.click_test_enable) begin
                pins_d      = cfg.relay_on_level ? (pins_q & ~ctl) : (pins_q | ctl);
                phase_d     = 1'b1;
                lst_d       = req_q.now_ms;
                restarted_d = 1'b1;
              end else if (has_ctl) begin
                pins_d[low_idx] = ~pins_q[low_idx];
                sw_d            = 1'b1;
                sw_idx_d        = low_idx;
                sw_on_d         = pins_q[low_idx] ^ cfg.relay_on_level;
              end
            end
          end
        end
      end
      ST_STEP: begin
        if (cfg.click_test_enable && time_ok) begin
          lst_d   = req_q.now_ms;
          state_d = ST_PICK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_PICK: begin
        if (cnt == '0) begin
          if (!retry_q) begin
            // empty phase: flip and retry with the same random word
            phase_d = ~phase_q;
            retry_d = 1'b1;
          end else begin
            state_d = ST_FINISH;
          end
        end else if (!mod_busy) begin
          cand_d    = cand;
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          nth_d   = mod_rem;
          idx_d   = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        idx_d = idx_q + IdxW'(1);
        if (cand_q[idx_q]) begin
          if (nth_q == '0) begin
            pins_d[idx_q] = phase_q ? cfg.relay_on_level : ~cfg.relay_on_level;
            sw_d          = 1'b1;
            sw_idx_d      = idx_q;
            sw_on_d       = phase_q;
            state_d       = ST_FINISH;
          end else begin
            nth_d = nth_q - CntW'(1);
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.relay_on_mask  = MaskW'(onm);
          out_d.switched       = sw_q;
          out_d.switched_index = 3'(sw_idx_q);
          out_d.switched_on    = sw_on_q;
          out_d.restarted      = restarted_q;
          out_d.pressed        = pressed_q;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pins_q      <= '0;
      was_down_q  <= 1'b0;
      lbt_q       <= '0;
      lst_q       <= '0;
      phase_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pins_q      <= pins_d;
      was_down_q  <= was_down_d;
      lbt_q       <= lbt_d;
      lst_q       <= lst_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    sw_q        <= sw_d;
    sw_idx_q    <= sw_idx_d;
    sw_on_q     <= sw_on_d;
    restarted_q <= restarted_d;
    pressed_q   <= pressed_d;
    retry_q     <= retry_d;
    cand_q      <= cand_d;
    idx_q       <= idx_d;
    nth_q       <= nth_d;
    out_q       <= out_d;
  end

  a_switch_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.switched) |->
      (out_rsp_o.relay_on_mask[out_rsp_o.switched_index] == out_rsp_o.switched_on))
    else $error("switched relay disagrees with on mask");
  a_restart_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.restarted) |-> out_rsp_o.pressed)
    else $error("restart without press");
  a_search_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (cand_q != '0))
    else $error("search with no candidate");

endmodule

@@ tb/tb_relay_bank_click_test_controller_core.sv @@
module tb_relay_bank_click_test_controller_core;
  import rbct_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  in_req_t          in_req = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_rsp_t         out_rsp;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  relay_bank_click_test_controller_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the relay bank: registers and state
  cfg_t        relay_cfg = '{controllable_mask: 8'hFF, click_test_enable: 1'b0,
                             relay_on_level: 1'b1, button_pressed_level: 1'b0,
                             debounce_ms: 16'd50, step_ms: 16'd1000};
  logic [7:0]  pin_lv = 8'h00;
  logic        btn_down = 1'b0;
  logic [31:0] last_btn_ms = '0;
  logic [31:0] last_step_ms = '0;
  logic        on_phase = 1'b1;

  in_req_t  relay_req_q[$];
  out_rsp_t expected_rsp_q[$];
  int       issued_cnt = 0;
  int       acc_cnt = 0;
  int       done_cnt = 0;
  int       err_cnt = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       in_gap_pct = 0;
  int       out_stall_pct = 0;

  // stimulus timeline and physical button
  logic [31:0] t_ms = '0;
  logic        btn_phys = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1000000);
    $display("FAILURE");
    $finish;
  end

  function automatic void drive_relay(logic [3:0] idx, logic on, inout out_rsp_t rsp);
    if (idx >= OUTPUT_COUNT_DEF || !relay_cfg.controllable_mask[idx[2:0]]) return;
    pin_lv[idx[2:0]] = on ? relay_cfg.relay_on_level : ~relay_cfg.relay_on_level;
    rsp.switched       = 1'b1;
    rsp.switched_index = idx[2:0];
    rsp.switched_on    = on;
  endfunction

  // candidate number (rnd mod count) among relays not yet at lvl
  function automatic int find_candidate(logic lvl, logic [31:0] rnd);
    logic [31:0] cnt;
    logic [31:0] nth;
    cnt = '0;
    for (int i = 0; i < 8; i++)
      if (relay_cfg.controllable_mask[i] && pin_lv[i] != lvl) cnt++;
    if (cnt == 0) return -1;
    nth = rnd % cnt;
    for (int i = 0; i < 8; i++)
      if (relay_cfg.controllable_mask[i] && pin_lv[i] != lvl) begin
        if (nth == 0) return i;
        nth--;
      end
    return -1;
  endfunction

  function automatic out_rsp_t predict_relays(in_req_t rq);
    out_rsp_t    rsp;
    logic        down;
    logic [31:0] dt;
    logic        tgt;
    int          idx;
    rsp = '0;
    if (rq.mode) begin
      drive_relay(rq.target_index, rq.target_on, rsp);
    end else begin
      down = (rq.button_level == relay_cfg.button_pressed_level);
      dt = rq.now_ms - last_btn_ms;
      if (down != btn_down && dt >= 32'(relay_cfg.debounce_ms)) begin
        last_btn_ms = rq.now_ms;
        btn_down = down;
        if (down) begin
          rsp.pressed = 1'b1;
          if (relay_cfg.click_test_enable) begin
            if (relay_cfg.relay_on_level) pin_lv &= ~relay_cfg.controllable_mask;
            else pin_lv |= relay_cfg.controllable_mask;
            on_phase = 1'b1;
            last_step_ms = rq.now_ms;
            rsp.restarted = 1'b1;
          end else begin
            for (int i = 0; i < 8; i++)
              if (relay_cfg.controllable_mask[i]) begin
                drive_relay(4'(i), pin_lv[i] != relay_cfg.relay_on_level, rsp);
                break;
              end
          end
        end
      end
      dt = rq.now_ms - last_step_ms;
      if (relay_cfg.click_test_enable && dt >= 32'(relay_cfg.step_ms)) begin
        last_step_ms = rq.now_ms;
        tgt = on_phase ? relay_cfg.relay_on_level : ~relay_cfg.relay_on_level;
        idx = find_candidate(tgt, rq.random_word);
        if (idx < 0) begin
          // phase done: flip and retry with the same random word
          on_phase = ~on_phase;
          tgt = on_phase ? relay_cfg.relay_on_level : ~relay_cfg.relay_on_level;
          idx = find_candidate(tgt, rq.random_word);
        end
        if (idx >= 0) drive_relay(4'(idx), tgt == relay_cfg.relay_on_level, rsp);
      end
    end
    for (int i = 0; i < 8; i++)
      rsp.relay_on_mask[i] = (pin_lv[i] == relay_cfg.relay_on_level);
    return rsp;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (in_valid && acc_cnt != issued_cnt) begin
      // request still waiting, hold it
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left = gap_left - 1;
    end else if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(0, 14);
    end else if (relay_req_q.size() != 0) begin
      in_valid <= 1'b1;
      in_req <= relay_req_q.pop_front();
      issued_cnt++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_rsp_t want;
    if (rst_n) begin
      // result first: it always belongs to an older request
      if (out_valid && !out_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_rsp);
          err_cnt++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("relay_on_mask", want.relay_on_mask, out_rsp.relay_on_mask);
          check_field("switched", want.switched, out_rsp.switched);
          check_field("switched_index", want.switched_index, out_rsp.switched_index);
          check_field("switched_on", want.switched_on, out_rsp.switched_on);
          check_field("restarted", want.restarted, out_rsp.restarted);
          check_field("pressed", want.pressed, out_rsp.pressed);
          done_cnt <= done_cnt + 1;
        end
      end
      if (in_valid && !in_stall) begin
        expected_rsp_q.push_back(predict_relays(in_req));
        acc_cnt <= acc_cnt + 1;
      end
    end
  end

  task automatic wait_drained();
    while (relay_req_q.size() != 0 || done_cnt != issued_cnt) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(reg_idx_e r, logic [31:0] v);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_CTL_MASK:    relay_cfg.controllable_mask = v[7:0];
      REG_TEST_EN:     relay_cfg.click_test_enable = v[0];
      REG_ON_LEVEL:    relay_cfg.relay_on_level = v[0];
      REG_PRESS_LEVEL: relay_cfg.button_pressed_level = v[0];
      REG_DEBOUNCE:    relay_cfg.debounce_ms = v[15:0];
      REG_STEP:        relay_cfg.step_ms = v[15:0];
      default: ;
    endcase
  endtask

  task automatic push_pass(logic [31:0] now, logic btn, logic [31:0] rnd);
    in_req_t rq;
    rq.mode         = 1'b0;
    rq.now_ms       = now;
    rq.button_level = btn;
    rq.random_word  = rnd;
    rq.target_index = 4'($urandom);
    rq.target_on    = 1'($urandom);
    relay_req_q.push_back(rq);
  endtask

  task automatic push_set(logic [3:0] idx, logic on);
    in_req_t rq;
    rq.mode         = 1'b1;
    rq.now_ms       = $urandom;
    rq.button_level = 1'($urandom);
    rq.random_word  = $urandom;
    rq.target_index = idx;
    rq.target_on    = on;
    relay_req_q.push_back(rq);
  endtask

  function automatic logic [15:0] pick_interval();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'($urandom_range(1, 5));
      2:       return 16'($urandom_range(1, 20));
      3:       return 16'($urandom_range(20, 200));
      4:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 40;
    endcase
  endfunction

  task automatic run_random_phase(int n_items, bit quiet);
    logic [7:0]  m;
    logic [15:0] db;
    logic [15:0] st;
    int          span;
    int          r;
    case ($urandom_range(0, 5))
      0:       m = 8'h00;
      1, 2:    m = 8'hFF;
      3:       m = 8'h01 << $urandom_range(0, 7);
      default: m = 8'($urandom);
    endcase
    db = pick_interval();
    st = pick_interval();
    // junk in the upper bits must be dropped by the register file
    set_reg(REG_CTL_MASK, ($urandom & 32'hFFFF_FF00) | 32'(m));
    set_reg(REG_TEST_EN, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 2) != 0));
    set_reg(REG_ON_LEVEL, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1)));
    set_reg(REG_PRESS_LEVEL, ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1)));
    set_reg(REG_DEBOUNCE, ($urandom & 32'hFFFF_0000) | 32'(db));
    set_reg(REG_STEP, ($urandom & 32'hFFFF_0000) | 32'(st));
    in_gap_pct    = quiet ? 0 : pick_pct();
    out_stall_pct = quiet ? 0 : pick_pct();
    span = ((db > st ? int'(db) : int'(st)) >> 1) + 2;
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        push_set($urandom_range(0, 3) == 0 ? 4'($urandom_range(8, 15))
                                            : 4'($urandom_range(0, 7)),
                 1'($urandom));
      end else if (r < 23) begin
        // time jump with a random button level
        t_ms = $urandom;
        push_pass(t_ms, 1'($urandom), $urandom);
      end else begin
        t_ms = t_ms + 32'($urandom_range(0, span));
        if ($urandom_range(0, 2) == 0) btn_phys = ~btn_phys;
        push_pass(t_ms, btn_phys, $urandom);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    in_gap_pct    = 20;
    out_stall_pct = 20;

    // defaults: set requests, out of range, debounce lockout, toggle on press
    push_set(4'd0, 1'b1);
    push_set(4'd7, 1'b1);
    push_set(4'd7, 1'b0);
    push_set(4'd8, 1'b1);
    push_set(4'd15, 1'b0);
    push_pass(32'd10, 1'b0, $urandom);
    push_pass(32'd60, 1'b0, $urandom);
    push_pass(32'd70, 1'b1, $urandom);
    push_pass(32'd200, 1'b1, $urandom);
    push_pass(32'd300, 1'b0, $urandom);
    push_pass(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);

    // nothing controllable: request ignored, press only reported
    set_reg(REG_CTL_MASK, 32'h0000_0000);
    push_set(4'd3, 1'b1);
    push_pass(32'd100, 1'b0, 32'h0);

    // click test with zero intervals, inverted levels, wrapping time
    set_reg(REG_CTL_MASK, 32'h0000_00FF);
    set_reg(REG_TEST_EN, 32'h1);
    set_reg(REG_ON_LEVEL, 32'h0);
    set_reg(REG_PRESS_LEVEL, 32'h1);
    set_reg(REG_DEBOUNCE, 32'h0);
    set_reg(REG_STEP, 32'h0);
    push_pass(32'd200, 1'b0, 32'h0);
    push_pass(32'd200, 1'b1, 32'hFFFF_FFFF);
    push_pass(32'hFFFF_FFF0, 1'b1, $urandom);
    push_pass(32'h0000_0010, 1'b1, $urandom);
    push_pass(32'h0000_0010, 1'b1, $urandom);
    push_pass(32'h0000_0011, 1'b1, $urandom);
    push_set(4'd5, 1'b0);

    // widest intervals, sparse mask
    set_reg(REG_DEBOUNCE, 32'h0000_FFFF);
    set_reg(REG_STEP, 32'h0000_FFFF);
    set_reg(REG_CTL_MASK, 32'h0000_0081);
    push_pass(32'h0001_0000, 1'b0, $urandom);
    push_pass(32'h0002_0000, 1'b0, $urandom);
    push_pass(32'h0002_FFFF, 1'b1, $urandom);
    push_pass(32'h0003_FFFE, 1'b1, $urandom);

    t_ms = $urandom;
    for (int p = 0; p < 10; p++) run_random_phase(55, p == 9);

    wait_drained();
    repeat (64) @(posedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
